[sv/sst_pkg.sv]
package sst_pkg;

  localparam int SST_DEPTH     = 16;
  localparam int SST_KEY_WIDTH = 8;
  localparam int SST_CMD_W     = 2;
  localparam int SST_CNT_W     = 5;

  // Command codes; the unused code behaves as a find.
  typedef enum logic [SST_CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_FIND = 2'd2
  } sst_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_SHIFT,
    ST_RESP
  } sst_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic start;
    logic scan_en;
    logic apply;
    logic shift_en;
    logic resp_load;
  } sst_ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic del_shift;
    logic shift_done;
    logic out_free;
  } sst_sts_t;

endpackage

[sv/sst_in_if.sv]
interface sst_in_if
  import sst_pkg::*;
#(
  parameter int KEY_WIDTH = SST_KEY_WIDTH
) ();
  logic                 valid;
  logic                 ready;
  logic [SST_CMD_W-1:0] cmd;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

[sv/sst_out_if.sv]
interface sst_out_if
  import sst_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [SST_CNT_W-1:0] count;
  logic                 full_drop;

  modport source (output valid, output hit, output count, output full_drop, input ready);
  modport sink   (input valid, input hit, input count, input full_drop, output ready);
endinterface

[sv/sst_ram.sv]
module sst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/sst_ctrl.sv]
module sst_ctrl
  import sst_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  sst_sts_t sts,
  output sst_ctl_t ctl
);

  sst_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        state_nxt = sts.del_shift ? ST_SHIFT : ST_RESP;
      end
      ST_SHIFT: begin
        if (sts.shift_done) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ctl.start = in_valid;
      end
      ST_SCAN:  ctl.scan_en   = 1'b1;
      ST_APPLY: ctl.apply     = 1'b1;
      ST_SHIFT: ctl.shift_en  = 1'b1;
      ST_RESP:  ctl.resp_load = sts.out_free;
      default: begin
        ctl      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[sv/sst_dp.sv]
module sst_dp
  import sst_pkg::*;
#(
  parameter int DEPTH     = SST_DEPTH,
  parameter int KEY_WIDTH = SST_KEY_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sst_ctl_t             ctl,
  output sst_sts_t             sts,
  input  logic [SST_CMD_W-1:0] in_cmd,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [SST_CNT_W-1:0] out_count,
  output logic                 out_full_drop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [SST_CMD_W-1:0] cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CW-1:0]        cnt_r;
  logic [CW-1:0]        idx_r;
  logic                 pvld_r;
  logic [AW-1:0]        pidx_r;
  logic                 hit_r;
  logic [AW-1:0]        pos_r;
  logic                 drop_r;
  logic                 out_vld_r;
  logic                 out_hit_r;
  logic [SST_CNT_W-1:0] out_cnt_r;
  logic                 out_drop_r;

  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [KEY_WIDTH-1:0] wr_data;
  logic [KEY_WIDTH-1:0] rd_data;

  logic                 match_now;
  logic                 more;
  logic                 issue;
  logic                 add_ok;
  logic                 is_add;
  logic                 shift_done;
  logic [CW+SST_CNT_W-1:0] cnt_ext;

  sst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  assign match_now  = ctl.scan_en && pvld_r && (rd_data == key_r);
  assign more       = idx_r < cnt_r;
  assign issue      = more && !match_now;
  assign is_add     = cmd_r == CMD_ADD;
  assign add_ok     = is_add && !hit_r && (cnt_r < CW'(DEPTH));
  assign shift_done = !pvld_r && !more;

  // Write port: append on add, copy entry down by one during a delete shift.
  assign wr_en   = (ctl.apply && add_ok) || (ctl.shift_en && pvld_r);
  assign wr_addr = ctl.apply ? cnt_r[AW-1:0] : pidx_r;
  assign wr_data = ctl.apply ? key_r : rd_data;

  assign sts.scan_done  = match_now || hit_r || (!pvld_r && !more);
  assign sts.del_shift  = (cmd_r == CMD_DEL) && hit_r;
  assign sts.shift_done = shift_done;
  assign sts.out_free   = !out_vld_r || out_ready;

  assign cnt_ext = (CW+SST_CNT_W)'(cnt_r);

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
    end
    if (ctl.scan_en && match_now) begin
      pos_r <= pidx_r;
    end
    if (ctl.apply) begin
      drop_r <= is_add && !hit_r && !add_ok;
    end
    if (ctl.scan_en) begin
      pidx_r <= idx_r[AW-1:0];
    end else if (ctl.shift_en) begin
      pidx_r <= AW'(idx_r - CW'(1));
    end
    if (ctl.resp_load) begin
      out_hit_r  <= hit_r;
      out_cnt_r  <= cnt_ext[SST_CNT_W-1:0];
      out_drop_r <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      idx_r     <= '0;
      pvld_r    <= 1'b0;
      hit_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (ctl.start) begin
        idx_r  <= '0;
        pvld_r <= 1'b0;
        hit_r  <= 1'b0;
      end else if (ctl.scan_en) begin
        if (match_now) hit_r <= 1'b1;
        if (issue) idx_r <= idx_r + CW'(1);
        pvld_r <= issue;
      end else if (ctl.apply) begin
        idx_r  <= CW'(pos_r) + CW'(1);
        pvld_r <= 1'b0;
        if (add_ok) cnt_r <= cnt_r + CW'(1);
      end else if (ctl.shift_en) begin
        if (more) idx_r <= idx_r + CW'(1);
        pvld_r <= more;
        if (shift_done) cnt_r <= cnt_r - CW'(1);
      end

      if (ctl.resp_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_vld_r;
  assign out_hit       = out_hit_r;
  assign out_count     = out_cnt_r;
  assign out_full_drop = out_drop_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("stored count above depth");

  a_hit_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_hit_r && out_drop_r))
    else $error("hit and full drop together");

  a_shift_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift_en && wr_en) |-> (CW'(wr_addr) < cnt_r))
    else $error("shift write outside stored entries");

  a_shift_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.shift_en && shift_done) |-> (cnt_r != '0))
    else $error("delete with empty store");
`endif

endmodule

[sv/small_set_table.sv]
// small_set_table: bounded set of distinct keys, packed in insertion order.
// Completion time grows with the stored keys on a miss and with the hit position on
// a hit; a delete that hits also copies later entries down, and an output stall adds.
// A new transaction is taken only once the previous result has been posted.
// Reset (rst_n low, synchronous) clears control state and the key count; no RAM clear.
module small_set_table
  import sst_pkg::*;
#(
  parameter int DEPTH     = SST_DEPTH,
  parameter int KEY_WIDTH = SST_KEY_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  sst_in_if.sink    in_ch,
  sst_out_if.source out_ch
);

  // Command and status between controller and datapath.
  sst_ctl_t ctl;
  sst_sts_t sts;

  // Controller: idle -> scan -> apply -> (shift) -> response.
  // The input is taken only in idle; the finished result sits in the
  // output register so the next transaction can be taken while it waits.
  sst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath: key/command latch, pipelined scan over the entry RAM (address
  // issued each cycle, compare in the cycle after), append on add, and a
  // read-ahead copy loop that closes the gap on delete.
  sst_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .sts           (sts),
    .in_cmd        (in_ch.cmd),
    .in_key        (in_ch.key),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_hit       (out_ch.hit),
    .out_count     (out_ch.count),
    .out_full_drop (out_ch.full_drop)
  );

endmodule

[dv/small_set_table_test.sv]
module small_set_table_test
  import sst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Code 3 has no enum member; the block treats it as a find.
  localparam logic [SST_CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int IDLE_PCT       = 34;    // chance in 100 that a side idles
  localparam int RANDOM_OPS     = 400;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int HOLD_AT_REPLY  = 60;    // reply count that triggers the hold-off
  localparam int STEADY_LO      = 150;   // no idling between these counts
  localparam int STEADY_HI      = 250;
  localparam int DRAIN_CYCLES   = 40;    // settle time at the end
  localparam int STALL_LIMIT    = 3000;  // cycles with no transaction at all
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [SST_CMD_W-1:0]     cmd;
    logic [SST_KEY_WIDTH-1:0] key;
  } set_op_t;

  typedef struct packed {
    logic                 hit;
    logic [SST_CNT_W-1:0] count;
    logic                 full_drop;
  } set_reply_t;

  logic clk;
  logic rst_n;

  sst_in_if #(.KEY_WIDTH(SST_KEY_WIDTH)) in_ch ();
  sst_out_if                             out_ch ();

  small_set_table #(
    .DEPTH    (SST_DEPTH),
    .KEY_WIDTH(SST_KEY_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow copy of the set: packed keys in insertion order plus the count.
  logic [SST_KEY_WIDTH-1:0] shadow_keys [SST_DEPTH];
  int                       shadow_count;

  set_op_t    pending_ops[$];       // ops not yet offered to the block
  set_reply_t expected_replies[$];  // replies owed for accepted ops

  int      ops_taken;
  int      replies_seen;
  int      mismatch_count;
  int      hold_left;
  int      stall_cycles;
  set_op_t next_op;

  // Applies one accepted op to the shadow set and returns the reply it owes.
  function automatic set_reply_t apply_set_op(set_op_t op);
    int         pos;
    int         i;
    set_reply_t r;
    pos = -1;
    for (i = 0; i < shadow_count; i++) begin
      if (pos < 0 && shadow_keys[i] == op.key) pos = i;
    end
    r.hit       = (pos >= 0);
    r.full_drop = 1'b0;
    case (op.cmd)
      CMD_ADD: begin
        if (pos < 0) begin
          if (shadow_count < SST_DEPTH) begin
            shadow_keys[shadow_count] = op.key;
            shadow_count++;
          end else begin
            r.full_drop = 1'b1;
          end
        end
      end
      CMD_DEL: begin
        if (pos >= 0) begin
          // close the gap, keep insertion order
          for (i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count--;
        end
      end
      default: ;  // find and the unused code leave the set alone
    endcase
    r.count = SST_CNT_W'(shadow_count);
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input driver: takes ops from pending_ops, holds an offer until accepted,
  // idles at random except in the steady window.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_replies.push_back(apply_set_op('{cmd: in_ch.cmd, key: in_ch.key}));
        ops_taken++;
      end
      if (in_ch.valid && !in_ch.ready) begin
        // offer stands until the block takes it
      end else if (pending_ops.size() > 0 &&
                   ((ops_taken >= STEADY_LO && ops_taken < STEADY_HI) ||
                    $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_op = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd   <= next_op.cmd;
        in_ch.key   <= next_op.key;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each reply against the oldest expectation and
  // throttles ready, including one long hold-off so the input backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] unexpected reply: hit=%0b count=%0d full_drop=%0b",
                     $realtime, out_ch.hit, out_ch.count, out_ch.full_drop);
        end else begin
          set_reply_t want;
          want = expected_replies.pop_front();
          if (out_ch.hit !== want.hit || out_ch.count !== want.count ||
              out_ch.full_drop !== want.full_drop) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("[%0t] reply %0d mismatch: hit %0b/%0b count %0d/%0d full_drop %0b/%0b",
                       $realtime, replies_seen, want.hit, out_ch.hit, want.count,
                       out_ch.count, want.full_drop, out_ch.full_drop);
          end
        end
        if (replies_seen == HOLD_AT_REPLY) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (replies_seen >= STEADY_LO && replies_seen < STEADY_HI) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any transaction on either side resets the stall count.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[%0t] timeout: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [SST_KEY_WIDTH-1:0] key_pool [24];
    int                       add_pct;
    int                       del_pct;
    int                       roll;
    int                       i;
    set_op_t                  op;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_FIND;
    in_ch.key      = '0;
    out_ch.ready   = 1'b0;
    shadow_count   = 0;
    ops_taken      = 0;
    replies_seen   = 0;
    mismatch_count = 0;
    hold_left      = 0;
    stall_cycles   = 0;

    // Directed: empty-set misses, fill to capacity with keys that toggle
    // every key bit (0x00 .. 0xFF in steps of 0x11), then a drop on full,
    // a re-add of a present key, deletes at front/back/middle, and the
    // unused command code on both a present and an absent key.
    pending_ops.push_back('{cmd: CMD_FIND, key: 8'h00});
    pending_ops.push_back('{cmd: CMD_DEL,  key: 8'h55});
    for (i = 0; i < SST_DEPTH; i++)
      pending_ops.push_back('{cmd: CMD_ADD, key: SST_KEY_WIDTH'(i * 17)});
    pending_ops.push_back('{cmd: CMD_ADD,    key: 8'h5A});  // full: dropped
    pending_ops.push_back('{cmd: CMD_ADD,    key: 8'h22});  // already present
    pending_ops.push_back('{cmd: CMD_DEL,    key: 8'h00});  // front, shifts all
    pending_ops.push_back('{cmd: CMD_DEL,    key: 8'hFF});  // last entry
    pending_ops.push_back('{cmd: CMD_DEL,    key: 8'h88});  // middle
    pending_ops.push_back('{cmd: CMD_UNUSED, key: 8'h11});
    pending_ops.push_back('{cmd: CMD_UNUSED, key: 8'h5A});
    pending_ops.push_back('{cmd: CMD_FIND,   key: 8'h88});

    // Random: mostly keys from a small pool so the set fills, hits and
    // drains; phases swing between add-heavy and delete-heavy mixes.
    for (i = 0; i < 24; i++) key_pool[i] = SST_KEY_WIDTH'($urandom_range(0, 255));
    add_pct = 50;
    del_pct = 20;
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (i % 50 == 0) begin
        case ((i / 50) % 3)
          0: begin add_pct = 60; del_pct = 15; end
          1: begin add_pct = 20; del_pct = 55; end
          default: begin add_pct = 35; del_pct = 35; end
        endcase
        key_pool[$urandom_range(0, 23)] = SST_KEY_WIDTH'($urandom_range(0, 255));
      end
      roll = $urandom_range(0, 99);
      if (roll < add_pct)                op.cmd = CMD_ADD;
      else if (roll < add_pct + del_pct) op.cmd = CMD_DEL;
      else if (roll < 95)                op.cmd = CMD_FIND;
      else                               op.cmd = CMD_UNUSED;
      if ($urandom_range(0, 99) < 85) op.key = key_pool[$urandom_range(0, 23)];
      else                            op.key = SST_KEY_WIDTH'($urandom_range(0, 255));
      pending_ops.push_back(op);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() > 0 || in_ch.valid || expected_replies.size() > 0)
      @(posedge clk);
    // catch any stray reply the block might still emit
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/sst_pkg.sv
sv/sst_in_if.sv
sv/sst_out_if.sv
sv/sst_ram.sv
sv/sst_ctrl.sv
sv/sst_dp.sv
sv/small_set_table.sv
dv/small_set_table_test.sv
